// ----- rtl/hfcm_pkg.sv -----
`default_nettype none

package hfcm_pkg;

  localparam int FS_BITS = 15;
  localparam logic [FS_BITS-1:0] FS_RESET = 15'd1000;

  localparam int COLOR_BITS = 8;
  localparam logic [COLOR_BITS-1:0] COLOR_MAX = 8'd255;
  localparam logic [COLOR_BITS-1:0] BLUE_BASE = 8'd100;

  // scaled ramp value ahead of the divide by 33 or 34, always below 2^14
  localparam int RAMP_BITS = 14;

  // v / d as (v * floor(2^20 / d)) >> 20, then one correction step
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_BITS = 15;
  localparam logic [RECIP_BITS-1:0] RECIP_33 = 15'd31775;
  localparam logic [RECIP_BITS-1:0] RECIP_34 = 15'd30840;
  localparam int DIV_BITS = 6;
  localparam logic [DIV_BITS-1:0] DIV_33 = 6'd33;
  localparam logic [DIV_BITS-1:0] DIV_34 = 6'd34;
  localparam int QUOT_BITS = 9;

  typedef enum logic [1:0] {
    SEG_LOW,
    SEG_MID,
    SEG_HIGH
  } seg_t;

endpackage

`default_nettype wire

// ----- rtl/hfcm_if.sv -----
`default_nettype none

interface hfcm_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] temperature;

  modport source(output valid, output temperature, input ready);
  modport sink(input valid, input temperature, output ready);
endinterface

interface hfcm_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- rtl/heat_false_color_map_core.sv -----
// Heat false-color map: one signed temperature sample in, one RGB color out.
// samples (sink): valid/ready/temperature, a transaction at each clock edge
//   with valid and ready both high. colors (source): valid/ready/red/green/blue.
// cfg_we/cfg_wdata write full_scale (the temperature shown as white); write it
//   only while no sample is in flight. A value of zero acts as one.
// Samples below zero give dark blue, samples above full_scale give white.
// Throughput: one sample per clock while the output is not stalled. The ratio
//   t/full_scale comes from a restoring divider with one quotient bit per
//   stage, so the pipe is RATIO_FRAC_BITS + 6 registers deep.
// Stall: each stage holds while it is full and the next one cannot take it;
//   empty stages keep filling, so samples are still taken until the pipe is full.
// Reset (rst, synchronous): empties the pipe and sets full_scale to 1000.
`default_nettype none

module heat_false_color_map_core
  import hfcm_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  hfcm_sample_if.sink             samples,
  hfcm_color_if.source            colors,
  input  wire logic               cfg_we,
  input  wire logic [FS_BITS-1:0] cfg_wdata
);

  logic [FS_BITS-1:0]     full_scale;
  logic [FS_BITS-1:0]     fs_eff;
  logic                   ratio_valid;
  logic                   ratio_ready;
  logic [RATIO_FRAC_BITS:0] ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FS_RESET;
    end else if (cfg_we) begin
      full_scale <= cfg_wdata;
    end
  end

  assign fs_eff = (full_scale == '0) ? FS_BITS'(1) : full_scale;

  hfcm_ratio #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (RATIO_FRAC_BITS)
  ) u_ratio (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .temperature (samples.temperature),
    .full_scale  (fs_eff),
    .out_valid   (ratio_valid),
    .out_ready   (ratio_ready),
    .ratio       (ratio)
  );

  hfcm_ramp #(
    .FRAC_BITS (RATIO_FRAC_BITS)
  ) u_ramp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ratio_valid),
    .in_ready  (ratio_ready),
    .ratio     (ratio),
    .out_valid (colors.valid),
    .out_ready (colors.ready),
    .red       (colors.red),
    .green     (colors.green),
    .blue      (colors.blue)
  );

endmodule

`default_nettype wire

// ----- rtl/hfcm_ratio.sv -----
`default_nettype none

module hfcm_ratio
  import hfcm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] temperature,
  input  wire logic [FS_BITS-1:0]            full_scale,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [FRAC_BITS:0]                 ratio
);

  localparam int STAGES = FRAC_BITS + 2;
  localparam int QW     = FRAC_BITS + 1;
  localparam int CW     = (SAMPLE_BITS > FS_BITS + 1) ? SAMPLE_BITS : FS_BITS + 1;
  localparam logic [QW-1:0] RATIO_ONE = QW'(1) << FRAC_BITS;

  logic              vld [STAGES];
  logic              adv [STAGES];
  logic [FS_BITS-1:0] rem [STAGES];
  logic [QW-1:0]     quo [STAGES];

  logic [CW-1:0]      t_ext;
  logic [CW-1:0]      fs_ext;
  logic [FS_BITS-1:0] t_next;

  assign t_ext  = CW'($unsigned(temperature));
  assign fs_ext = CW'(full_scale);

  always_comb begin
    if (temperature[SAMPLE_BITS-1]) begin
      t_next = '0;
    end else if (t_ext > fs_ext) begin
      t_next = full_scale;
    end else begin
      t_next = t_ext[FS_BITS-1:0];
    end
  end

  // clamp stage
  assign adv[0] = !vld[0] || adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= in_valid;
    end
    if (adv[0]) begin
      rem[0] <= t_next;
      quo[0] <= '0;
    end
  end

  // restoring divide, one quotient bit per stage, MSB (integer bit) first
  for (genvar i = 1; i < STAGES; i++) begin : g_div
    logic [FS_BITS:0]   x;
    logic [FS_BITS-1:0] diff;
    logic               ge;

    if (i == 1) begin : g_first
      assign x = {1'b0, rem[i-1]};
    end else begin : g_rest
      assign x = {rem[i-1], 1'b0};
    end

    assign diff = x[FS_BITS-1:0] - full_scale;
    assign ge   = (x >= {1'b0, full_scale});

    if (i == STAGES - 1) begin : g_last
      assign adv[i] = !vld[i] || out_ready;
    end else begin : g_mid
      assign adv[i] = !vld[i] || adv[i+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv[i]) begin
        vld[i] <= vld[i-1];
      end
      if (adv[i]) begin
        rem[i] <= ge ? diff : x[FS_BITS-1:0];
        quo[i] <= {quo[i-1][QW-2:0], ge};
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[STAGES-1];
  assign ratio     = quo[STAGES-1];

`ifndef NO_ASSERTIONS
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ratio <= RATIO_ONE)
    else $error("ratio above full scale");
`endif

endmodule

`default_nettype wire

// ----- rtl/hfcm_ramp.sv -----
`default_nettype none

module hfcm_ramp
  import hfcm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FRAC_BITS:0]    ratio,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COLOR_BITS-1:0]      red,
  output logic [COLOR_BITS-1:0]      green,
  output logic [COLOR_BITS-1:0]      blue
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = FRAC_BITS + 7;
  localparam int PW = DW + COLOR_BITS;
  localparam int MW = RAMP_BITS + RECIP_BITS;
  localparam longint D33 = 33 * (longint'(1) << FRAC_BITS);
  localparam longint D66 = 66 * (longint'(1) << FRAC_BITS);
  localparam longint T1  = (D33 + 50) / 100;
  localparam longint T2  = (D66 + 50) / 100;
  localparam logic [DW-1:0] D33_W = DW'(D33);
  localparam logic [DW-1:0] D66_W = DW'(D66);
  localparam logic [QW-1:0] T1_W  = QW'(T1);
  localparam logic [QW-1:0] T2_W  = QW'(T2);

  function automatic logic [COLOR_BITS-1:0] sat_color(input logic [QUOT_BITS-1:0] v);
    logic [COLOR_BITS-1:0] r;
    if (v > QUOT_BITS'(COLOR_MAX)) begin
      r = COLOR_MAX;
    end else begin
      r = v[COLOR_BITS-1:0];
    end
    return r;
  endfunction

  logic adv_a, adv_b, adv_c, adv_d;
  logic vld_a, vld_b, vld_c, vld_d;

  // stage A: segment and offset from the segment start (low-segment blue: distance to its end)
  logic [DW-1:0] p100;
  seg_t          seg_next;
  logic [DW-1:0] dr_next, dg_next, db_next;
  seg_t          seg_a;
  logic [DW-1:0] dr_a, dg_a, db_a;

  assign p100 = DW'(ratio) * DW'(100);

  always_comb begin
    if (ratio < T1_W) begin
      seg_next = SEG_LOW;
    end else if (ratio < T2_W) begin
      seg_next = SEG_MID;
    end else begin
      seg_next = SEG_HIGH;
    end
    dr_next = '0;
    dg_next = '0;
    db_next = '0;
    case (seg_next)
      SEG_LOW: begin
        dr_next = p100;
        db_next = (D33_W > p100) ? D33_W - p100 : '0;
      end
      SEG_MID: begin
        dg_next = (p100 > D33_W) ? p100 - D33_W : '0;
      end
      SEG_HIGH: begin
        db_next = (p100 > D66_W) ? p100 - D66_W : '0;
      end
      default: begin
        dr_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (adv_a) begin
      vld_a <= in_valid;
    end
    if (adv_a) begin
      seg_a <= seg_next;
      dr_a  <= dr_next;
      dg_a  <= dg_next;
      db_a  <= db_next;
    end
  end

  // stage B: scale by channel span, drop fraction bits
  logic [PW-1:0]         pr, pg, pb;
  logic [COLOR_BITS-1:0] kb;
  seg_t                  seg_b;
  logic [RAMP_BITS-1:0]  vr_b, vg_b, vb_b;

  assign kb = (seg_a == SEG_LOW) ? BLUE_BASE : COLOR_MAX;
  assign pr = PW'(dr_a) * PW'(COLOR_MAX);
  assign pg = PW'(dg_a) * PW'(COLOR_MAX);
  assign pb = PW'(db_a) * PW'(kb);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else if (adv_b) begin
      vld_b <= vld_a;
    end
    if (adv_b) begin
      seg_b <= seg_a;
      vr_b  <= RAMP_BITS'(pr >> FRAC_BITS);
      vg_b  <= RAMP_BITS'(pg >> FRAC_BITS);
      vb_b  <= RAMP_BITS'(pb >> FRAC_BITS);
    end
  end

  // stage C: quotient estimate by reciprocal
  logic [RECIP_BITS-1:0] mb;
  logic [MW-1:0]         mr, mg, mbl;
  seg_t                  seg_c;
  logic [RAMP_BITS-1:0]  vr_c, vg_c, vb_c;
  logic [QUOT_BITS-1:0]  qr_c, qg_c, qb_c;

  assign mb  = (seg_b == SEG_HIGH) ? RECIP_34 : RECIP_33;
  assign mr  = MW'(vr_b) * MW'(RECIP_33);
  assign mg  = MW'(vg_b) * MW'(RECIP_33);
  assign mbl = MW'(vb_b) * MW'(mb);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else if (adv_c) begin
      vld_c <= vld_b;
    end
    if (adv_c) begin
      seg_c <= seg_b;
      vr_c  <= vr_b;
      vg_c  <= vg_b;
      vb_c  <= vb_b;
      qr_c  <= QUOT_BITS'(mr >> RECIP_SHIFT);
      qg_c  <= QUOT_BITS'(mg >> RECIP_SHIFT);
      qb_c  <= QUOT_BITS'(mbl >> RECIP_SHIFT);
    end
  end

  // stage D: one correction step, saturate, select by segment
  logic [DIV_BITS-1:0]   dvb;
  logic [RAMP_BITS-1:0]  rr, rg, rb;
  logic [QUOT_BITS-1:0]  fr, fg, fb;
  logic [COLOR_BITS-1:0] red_next, green_next, blue_next;

  assign dvb = (seg_c == SEG_HIGH) ? DIV_34 : DIV_33;
  assign rr  = vr_c - RAMP_BITS'(qr_c) * RAMP_BITS'(DIV_33);
  assign rg  = vg_c - RAMP_BITS'(qg_c) * RAMP_BITS'(DIV_33);
  assign rb  = vb_c - RAMP_BITS'(qb_c) * RAMP_BITS'(dvb);
  assign fr  = qr_c + QUOT_BITS'(rr >= RAMP_BITS'(DIV_33));
  assign fg  = qg_c + QUOT_BITS'(rg >= RAMP_BITS'(DIV_33));
  assign fb  = qb_c + QUOT_BITS'(rb >= RAMP_BITS'(dvb));

  always_comb begin
    case (seg_c)
      SEG_LOW: begin
        red_next   = sat_color(fr);
        green_next = '0;
        blue_next  = sat_color(fb);
      end
      SEG_MID: begin
        red_next   = COLOR_MAX;
        green_next = sat_color(fg);
        blue_next  = '0;
      end
      SEG_HIGH: begin
        red_next   = COLOR_MAX;
        green_next = COLOR_MAX;
        blue_next  = sat_color(fb);
      end
      default: begin
        red_next   = COLOR_MAX;
        green_next = COLOR_MAX;
        blue_next  = COLOR_MAX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
    end else if (adv_d) begin
      vld_d <= vld_c;
    end
    if (adv_d) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign adv_d     = !vld_d || out_ready;
  assign adv_c     = !vld_c || adv_d;
  assign adv_b     = !vld_b || adv_c;
  assign adv_a     = !vld_a || adv_b;
  assign in_ready  = adv_a;
  assign out_valid = vld_d;

`ifndef NO_ASSERTIONS
  a_green_needs_red: assert property (@(posedge clk) disable iff (rst)
    out_valid && green != '0 |-> red == COLOR_MAX)
    else $error("green ramp without full red");

  a_red_ramp_no_green: assert property (@(posedge clk) disable iff (rst)
    out_valid && red != COLOR_MAX |-> green == '0)
    else $error("low segment color inconsistent");

  a_red_corr: assert property (@(posedge clk) disable iff (rst)
    vld_c |-> rr < RAMP_BITS'(2 * DIV_33))
    else $error("red quotient estimate off by more than one");

  a_blue_corr: assert property (@(posedge clk) disable iff (rst)
    vld_c |-> rb < RAMP_BITS'(2 * dvb))
    else $error("blue quotient estimate off by more than one");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
  import hfcm_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int RATIO_BITS = 16;
  localparam longint UNIT = 64'sd1 <<< RATIO_BITS;
  localparam longint SPAN33 = 33 * UNIT;
  localparam longint SPAN34 = 34 * UNIT;
  localparam longint SPAN66 = 66 * UNIT;
  localparam longint BREAK1 = (SPAN33 + 50) / 100;
  localparam longint BREAK2 = (SPAN66 + 50) / 100;
  localparam int PIPE_CYCLES = RATIO_BITS + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 130;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } color_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [FS_BITS-1:0] cfg_wdata;

  hfcm_sample_if #(.SAMPLE_BITS(SAMPLE_W)) samples_if();
  hfcm_color_if colors_if();

  logic signed [SAMPLE_W-1:0] sample_queue[$];
  color_t color_exp[$];
  logic [FS_BITS-1:0] scale_model = FS_RESET;
  int idle_pct = 0;
  int src_gap = 0;
  int snk_gap = 0;
  int mismatches = 0;
  int color_count = 0;
  int cycle_count = 0;

  heat_false_color_map_core #(
    .SAMPLE_BITS(SAMPLE_W),
    .RATIO_FRAC_BITS(RATIO_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .samples(samples_if),
    .colors(colors_if),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [COLOR_BITS-1:0] clip_color(input longint v);
    if (v < 0) return '0;
    if (v > 255) return COLOR_MAX;
    return v[COLOR_BITS-1:0];
  endfunction

  function automatic color_t heat_color(input logic signed [SAMPLE_W-1:0] temp,
                                        input logic [FS_BITS-1:0] scale);
    longint fs, t, q, r, g, b;
    seg_t seg;
    color_t c;
    fs = (scale == '0) ? 64'sd1 : longint'(scale);
    t = (temp < 0) ? 64'sd0 : longint'(temp);
    if (t > fs) t = fs;
    q = (t <<< RATIO_BITS) / fs;
    if (q < BREAK1) seg = SEG_LOW;
    else if (q < BREAK2) seg = SEG_MID;
    else seg = SEG_HIGH;
    case (seg)
      SEG_LOW: begin
        r = (100 * q * 255) / SPAN33;
        g = 0;
        b = ((SPAN33 - 100 * q) * 100) / SPAN33;
      end
      SEG_MID: begin
        r = 255;
        b = 0;
        g = ((100 * q - SPAN33) * 255) / SPAN33;
      end
      default: begin
        r = 255;
        g = 255;
        b = ((100 * q - SPAN66) * 255) / SPAN34;
      end
    endcase
    c.red = clip_color(r);
    c.green = clip_color(g);
    c.blue = clip_color(b);
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_temperature(
      input logic [FS_BITS-1:0] scale);
    int fs, pick, v;
    fs = (scale == '0) ? 1 : int'(scale);
    pick = $urandom_range(0, 99);
    if (pick < 55) v = $urandom_range(0, fs);
    else if (pick < 65) v = (fs * 33) / 100 + int'($urandom_range(0, 4)) - 2;
    else if (pick < 75) v = (fs * 66) / 100 + int'($urandom_range(0, 4)) - 2;
    else if (pick < 90) v = $urandom;
    else begin
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = fs;
        2: v = fs + 1;
        3: v = -1;
        4: v = -32768;
        default: v = 32767;
      endcase
    end
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_channel(input string name, input logic [COLOR_BITS-1:0] got,
                               input logic [COLOR_BITS-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("color %0d %s: got %0d want %0d",
                                color_count, name, got, want));
  endtask

  task automatic fill_random(input int count);
    repeat (count) sample_queue.push_back(pick_temperature(scale_model));
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || samples_if.valid || color_exp.size() != 0)
      @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic write_full_scale(input logic [FS_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    scale_model = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
      samples_if.temperature <= '0;
      src_gap = 0;
    end else begin
      if (samples_if.valid && samples_if.ready)
        color_exp.push_back(heat_color(samples_if.temperature, scale_model));
      if (!samples_if.valid || samples_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          samples_if.valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          samples_if.valid <= 1'b1;
          samples_if.temperature <= sample_queue.pop_front();
          if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            src_gap = $urandom_range(1, 5);
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  // color sink and checker
  always @(posedge clk) begin
    color_t want;
    if (rst) begin
      colors_if.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (colors_if.valid && colors_if.ready) begin
        if (color_exp.size() == 0) begin
          report_mismatch($sformatf("unexpected color %0d/%0d/%0d",
                                    colors_if.red, colors_if.green, colors_if.blue));
        end else begin
          want = color_exp.pop_front();
          check_channel("red", colors_if.red, want.red);
          check_channel("green", colors_if.green, want.green);
          check_channel("blue", colors_if.blue, want.blue);
        end
        color_count++;
      end
      if (snk_gap > 0) begin
        snk_gap--;
        colors_if.ready <= 1'b0;
      end else begin
        colors_if.ready <= 1'b1;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          snk_gap = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL heat_false_color_map_core");
      $finish;
    end
  end

  initial begin
    logic [FS_BITS-1:0] scales[$];
    int idles[$];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    scales = '{15'd0, 15'd1, 15'd32767, 15'd2, 15'd7, 15'd100, 15'd1000,
               15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)),
               15'd1000};
    idles = '{35, 10, 50, 0, 25, 40, 15, 30, 20, 0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset full_scale of 1000: clamps, segment edges, bit patterns
    idle_pct = 20;
    sample_queue = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd329, 16'sd330,
                     16'sd331, 16'sd500, 16'sd659, 16'sd660, 16'sd661, 16'sd999,
                     16'sd1000, 16'sd1001, 16'sd32767, 16'sh5555, 16'shAAAA,
                     16'sh2AAA};
    fill_random(PHASE_ITEMS);
    wait_drained();

    foreach (scales[i]) begin
      write_full_scale(scales[i]);
      idle_pct = idles[i];
      fill_random(PHASE_ITEMS);
      wait_drained();
    end

    if (mismatches == 0) $display("PASS heat_false_color_map_core");
    else $display("FAIL heat_false_color_map_core");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/hfcm_pkg.sv
rtl/hfcm_if.sv
rtl/hfcm_ratio.sv
rtl/hfcm_ramp.sv
rtl/heat_false_color_map_core.sv
tb/tb.sv
